@@ design/temporal_direct_scale_factor_defines.svh @@
// Assertion macros for the temporal direct scale factor block.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef TEMPORAL_DIRECT_SCALE_FACTOR_DEFINES_SVH
`define TEMPORAL_DIRECT_SCALE_FACTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDSF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tdsf_pkg.sv @@
// Shared types and constants for the temporal direct scale factor block.
// No dependencies; imported by every module of the block.
package tdsf_pkg;

	localparam int POC_W  = 32;
	localparam int PAIR_W = 2;
	localparam int IDX_W  = 5;
	localparam int SF_W   = 15;
	localparam int DIST_W = 8;

	localparam int TDSF_LIST_ENTRIES = 32;
	localparam int TDSF_QUEUE_DEPTH  = 4;

	localparam int DIST_MIN = -128;
	localparam int DIST_MAX = 127;

	localparam int TX_BASE    = 16384;
	localparam int SF_MIN     = -1024;
	localparam int SF_MAX     = 1023;
	localparam int SF_NO_DIST = 9999;
	localparam int SF_ROUND   = 32;
	localparam int SF_SHIFT   = 6;

	typedef struct packed {
		logic signed [DIST_W-1:0] tb;
		logic signed [DIST_W-1:0] td;
		logic [PAIR_W-1:0]        pair;
		logic [IDX_W-1:0]         idx;
	} dist_entry_t;

	typedef struct packed {
		logic        valid;
		dist_entry_t entry;
	} front_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

@@ design/tdsf_front.sv @@
// Front end: holds the spatial direct register, filters requests and forms
// the clipped distances tb and td. Depends on tdsf_pkg.
module tdsf_front import tdsf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     spatial_direct,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic signed [POC_W-1:0]  cur_poc,
	input  logic signed [POC_W-1:0]  ref0_poc,
	input  logic signed [POC_W-1:0]  ref1_poc,
	input  logic [PAIR_W-1:0]        list_pair,
	input  logic [IDX_W-1:0]         entry_index,
	input  queue_stat_t              q_stat,
	output front_push_t              push,
	output logic                     spatial_q
);

	localparam logic [IDX_W:0] LIST_LIMIT = (IDX_W+1)'(TDSF_LIST_ENTRIES);
	localparam logic signed [POC_W:0] CLIP_LO = (POC_W+1)'(DIST_MIN);
	localparam logic signed [POC_W:0] CLIP_HI = (POC_W+1)'(DIST_MAX);

	function automatic logic signed [DIST_W-1:0] clip_dist(input logic signed [POC_W:0] v);
		logic signed [DIST_W-1:0] r;
		if (v < CLIP_LO) begin
			r = DIST_W'(DIST_MIN);
		end else if (v > CLIP_HI) begin
			r = DIST_W'(DIST_MAX);
		end else begin
			r = v[DIST_W-1:0];
		end
		return r;
	endfunction

	logic signed [POC_W:0] tb_full;
	logic signed [POC_W:0] td_full;
	logic                  keep;
	logic                  advance;
	logic                  valid_s1;
	dist_entry_t           entry_s1;

	// Differences are taken one bit wider so they cannot wrap.
	assign tb_full = (POC_W+1)'(cur_poc) - (POC_W+1)'(ref0_poc);
	assign td_full = (POC_W+1)'(ref1_poc) - (POC_W+1)'(ref0_poc);

	assign keep = !spatial_q && ({1'b0, entry_index} < LIST_LIMIT);

	assign advance    = !valid_s1 || !q_stat.full;
	assign item_stall = !advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spatial_q <= 1'b0;
		end else if (cfg_valid) begin
			spatial_q <= spatial_direct;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid) begin
			entry_s1.tb   <= clip_dist(tb_full);
			entry_s1.td   <= clip_dist(td_full);
			entry_s1.pair <= list_pair;
			entry_s1.idx  <= entry_index;
		end
	end

	assign push.valid = valid_s1;
	assign push.entry = entry_s1;

endmodule

@@ design/tdsf_queue.sv @@
// Short queue between the front end and the scaling pipeline.
// Depends on tdsf_pkg for the entry and status types.
module tdsf_queue import tdsf_pkg::*; #(
	parameter int DEPTH = TDSF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  front_push_t push,
	input  logic        pop,
	output dist_entry_t head,
	output queue_stat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

	dist_entry_t      slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full  = (count_q == FULL_COUNT);
	assign q_stat.empty = (count_q == '0);
	assign do_push = push.valid && !q_stat.full;
	assign do_pop  = pop && !q_stat.empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/tdsf_back.sv @@
// Scaling pipeline: divides 16384 + |td/2| by td over three stages, multiplies
// by tb, rounds, clips and holds the result. Depends on tdsf_pkg.
module tdsf_back import tdsf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dist_entry_t             head,
	input  queue_stat_t             q_stat,
	output logic                    pop,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [SF_W-1:0]  scale_factor,
	output logic [PAIR_W-1:0]       out_list_pair,
	output logic [IDX_W-1:0]        out_entry_index
);

	localparam int Q_W      = 15;
	localparam int STEPS    = 5;
	localparam int PROD_W   = 24;
	localparam logic [Q_W-1:0] NUM_BASE = Q_W'(TX_BASE);
	localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(SF_ROUND);
	localparam logic signed [PROD_W-1:0] SF_LO = PROD_W'(SF_MIN);
	localparam logic signed [PROD_W-1:0] SF_HI = PROD_W'(SF_MAX);

	typedef struct packed {
		logic [DIST_W-1:0] rem;
		logic [Q_W-1:0]    work;
	} div_state_t;

	typedef struct packed {
		logic [DIST_W-1:0]        divisor;
		logic                     neg;
		logic                     zero;
		logic signed [DIST_W-1:0] tb;
		logic [PAIR_W-1:0]        pair;
		logic [IDX_W-1:0]         idx;
	} back_ctl_t;

	// Restoring division, one quotient bit per step; the dividend shifts out
	// of the top of work while quotient bits shift in at the bottom.
	function automatic div_state_t div_steps(input div_state_t s, input logic [DIST_W-1:0] d);
		div_state_t     r;
		logic [DIST_W:0] trial;
		r = s;
		for (int i = 0; i < STEPS; i++) begin
			trial = {r.rem, r.work[Q_W-1]};
			if (trial >= {1'b0, d}) begin
				trial = trial - {1'b0, d};
				r.work = {r.work[Q_W-2:0], 1'b1};
			end else begin
				r.work = {r.work[Q_W-2:0], 1'b0};
			end
			r.rem = trial[DIST_W-1:0];
		end
		return r;
	endfunction

	logic                      adv;
	logic [DIST_W-1:0]         abs_td;
	logic                      valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	back_ctl_t                 ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	div_state_t                div_s1, div_s2, div_s3, div_s4;
	logic signed [Q_W:0]       tx;
	logic signed [PROD_W-1:0]  prod_s5;
	logic                      zero_s5;
	logic [PAIR_W-1:0]         pair_s5;
	logic [IDX_W-1:0]          idx_s5;
	logic signed [PROD_W-1:0]  rounded;
	logic signed [PROD_W-1:0]  shifted;
	logic signed [SF_W-1:0]    sf_next;

	// The whole pipeline moves together whenever the output slot frees up.
	assign adv = !result_valid || !result_stall;
	assign pop = adv && !q_stat.empty;

	// For td = -128 the 8-bit negation gives 128, which is the right magnitude.
	assign abs_td = head.td[DIST_W-1] ? DIST_W'(-head.td) : DIST_W'(head.td);

	assign tx = ctl_s4.neg ? -$signed({1'b0, div_s4.work}) : $signed({1'b0, div_s4.work});

	assign rounded = prod_s5 + ROUND_C;
	assign shifted = rounded >>> SF_SHIFT;

	always_comb begin
		if (zero_s5) begin
			sf_next = SF_W'(SF_NO_DIST);
		end else if (shifted < SF_LO) begin
			sf_next = SF_W'(SF_MIN);
		end else if (shifted > SF_HI) begin
			sf_next = SF_W'(SF_MAX);
		end else begin
			sf_next = shifted[SF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			valid_s5     <= 1'b0;
			result_valid <= 1'b0;
		end else if (adv) begin
			valid_s1     <= pop;
			valid_s2     <= valid_s1;
			valid_s3     <= valid_s2;
			valid_s4     <= valid_s3;
			valid_s5     <= valid_s4;
			result_valid <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1.divisor <= abs_td;
			ctl_s1.neg     <= head.td[DIST_W-1];
			ctl_s1.zero    <= (head.td == '0);
			ctl_s1.tb      <= head.tb;
			ctl_s1.pair    <= head.pair;
			ctl_s1.idx     <= head.idx;
			div_s1.rem     <= '0;
			div_s1.work    <= NUM_BASE + Q_W'(abs_td >> 1);

			ctl_s2 <= ctl_s1;
			div_s2 <= div_steps(div_s1, ctl_s1.divisor);
			ctl_s3 <= ctl_s2;
			div_s3 <= div_steps(div_s2, ctl_s2.divisor);
			ctl_s4 <= ctl_s3;
			div_s4 <= div_steps(div_s3, ctl_s3.divisor);

			prod_s5 <= PROD_W'(ctl_s4.tb) * PROD_W'(tx);
			zero_s5 <= ctl_s4.zero;
			pair_s5 <= ctl_s4.pair;
			idx_s5  <= ctl_s4.idx;

			scale_factor    <= sf_next;
			out_list_pair   <= pair_s5;
			out_entry_index <= idx_s5;
		end
	end

endmodule

@@ design/temporal_direct_scale_factor.sv @@
// Temporal direct distance scale factor, one request per list 0 entry.
// A request carries three order counts, the list pair and the entry index.
// The spatial_direct register is written over the cfg_valid/cfg_ready
// channel, which is always ready; while it is set, requests are taken and
// dropped without a result. Requests with an entry index at or above the
// list size are dropped as well.
// Throughput is one request per cycle while item_stall is low. With no
// stall an accepted request passes through one front stage, the queue,
// a prep stage, three divide stages of five quotient bits each and the
// multiply stage, after which the output register presents it.
// When result_stall is high while a result is waiting, the whole scaling
// pipeline holds; the queue then fills and item_stall rises once the front
// stage can no longer drain.
// Reset clears the register to 0, empties the queue and drops all requests
// in flight.
// Depends on tdsf_pkg, tdsf_front, tdsf_queue, tdsf_back and the defines header.
`include "temporal_direct_scale_factor_defines.svh"

module temporal_direct_scale_factor import tdsf_pkg::*; #(
	parameter int QUEUE_DEPTH = TDSF_QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    spatial_direct,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic signed [POC_W-1:0] cur_poc,
	input  logic signed [POC_W-1:0] ref0_poc,
	input  logic signed [POC_W-1:0] ref1_poc,
	input  logic [PAIR_W-1:0]       list_pair,
	input  logic [IDX_W-1:0]        entry_index,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [SF_W-1:0]  scale_factor,
	output logic [PAIR_W-1:0]       out_list_pair,
	output logic [IDX_W-1:0]        out_entry_index
);

	front_push_t push;
	queue_stat_t q_stat;
	dist_entry_t head;
	logic        pop;
	logic        spatial_q;

	tdsf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.spatial_direct (spatial_direct),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.cur_poc        (cur_poc),
		.ref0_poc       (ref0_poc),
		.ref1_poc       (ref1_poc),
		.list_pair      (list_pair),
		.entry_index    (entry_index),
		.q_stat         (q_stat),
		.push           (push),
		.spatial_q      (spatial_q)
	);

	tdsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	tdsf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.q_stat          (q_stat),
		.pop             (pop),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.scale_factor    (scale_factor),
		.out_list_pair   (out_list_pair),
		.out_entry_index (out_entry_index)
	);

	// The front end may only stall while the queue is full.
	`TDSF_ASSERT_SAME(a_stall_needs_full, item_stall, q_stat.full, "front stalled with queue space")
	`TDSF_ASSERT_SAME(a_full_not_empty, q_stat.full, !q_stat.empty, "queue full and empty at once")
	// A request taken in spatial direct mode must not reach the queue.
	`TDSF_ASSERT_NEXT(a_spatial_drop, item_valid && !item_stall && spatial_q, !push.valid,
		"request kept in spatial direct mode")

endmodule
